@@ rtl/core/sst_pkg.sv @@
package sst_pkg;

  // Default table size and register reset values.
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam logic [15:0] RSSI_LVL_RST    = 16'hFFFF;
  localparam logic [15:0] NOISE_LVL_RST   = 16'h0000;
  localparam logic [5:0]  HYST_RST        = 6'd14;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_MEAS  = 2'd0;
  localparam logic [1:0] REQ_BLACK = 2'd1;
  localparam logic [1:0] REQ_GOOD  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RSSI_LVL  = 2'd0;
  localparam logic [1:0] CFG_NOISE_LVL = 2'd1;
  localparam logic [1:0] CFG_HYST      = 2'd2;

  // One stored signal.
  typedef struct packed {
    logic [31:0] freq;
    logic [15:0] rssi;
    logic        is_open;
    logic        blacklisted;
    logic        marked_good;
  } entry_t;

  // Status handed from the search engine to the sequencer.
  typedef struct packed {
    logic   done;
    logic   found;
    entry_t entry;
  } srch_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESULT
  } sst_state_e;

endpackage

@@ rtl/core/sst_ram.sv @@
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sst_search.sv @@
module sst_search #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [31:0]        freq_i,
  input  sst_pkg::entry_t    rd_data_i,
  output logic               rd_en_o,
  output logic [SLOT_W-1:0]  rd_addr_o,
  output logic [SLOT_W-1:0]  slot_o,
  output sst_pkg::srch_res_t res_o
);
  import sst_pkg::*;

  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [SLOT_W-1:0] pend_idx_q, pend_idx_d;
  logic              match;
  logic              issue_more;
  logic              done;

  // One entry is read per cycle; the entry read last cycle is compared now.
  assign match      = busy_q && pend_q && (rd_data_i.freq == freq_i);
  assign issue_more = busy_q && !match && (issue_q < count_i);
  assign done       = busy_q && (match || (issue_q >= count_i));

  assign rd_en_o   = issue_more;
  assign rd_addr_o = issue_q[SLOT_W-1:0];
  assign slot_o    = pend_idx_q;

  assign res_o.done  = done;
  assign res_o.found = match;
  assign res_o.entry = rd_data_i;

  always_comb begin
    busy_d     = busy_q;
    pend_d     = pend_q;
    issue_d    = issue_q;
    pend_idx_d = pend_idx_q;
    if (start_i) begin
      busy_d  = 1'b1;
      pend_d  = 1'b0;
      issue_d = '0;
    end else if (done) begin
      busy_d = 1'b0;
      pend_d = 1'b0;
    end else if (busy_q) begin
      pend_d     = issue_more;
      pend_idx_d = issue_q[SLOT_W-1:0];
      if (issue_more) begin
        issue_d = issue_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pend_q  <= 1'b0;
      issue_q <= '0;
    end else begin
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      issue_q <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
  end

endmodule

@@ rtl/core/squelch_signal_table_top.sv @@
// Squelch decision with a table of heard signals.
// The input channel (in_valid_i / in_stall_o) carries one word: a measurement
// (frequency, RSSI, noise) or a command that blacklists or marks good the
// last-active table entry. Every accepted word yields exactly one result word
// on the output channel (out_valid_o / out_stall_i).
// The configuration port writes one register per cycle while cfg_we_i is high;
// it is meant to be used only while the block is idle.
// A measurement searches the table one entry per cycle through one RAM read
// port, then updates the entry it found or stores a new open one while there
// is room. A command does a read, modify, write of the last-active entry when
// one exists, and goes straight to its result otherwise.
// The block holds in_stall_o high for the whole time it works on a word.
// A finished result sits in an output register until it is taken; while the
// receiver stalls, the next word is still accepted and processed, and its
// result waits in the sequencer until the output register is free.
// Reset empties the table (entry count zero, no last-active entry, not
// listening) and loads the register defaults; the table RAM is not cleared,
// since only entries below the count are ever read.
module squelch_signal_table_top #(
  parameter int unsigned TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] frequency_i,
  input  logic [15:0] rssi_value_i,
  input  logic [15:0] noise_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        squelch_open_o,
  output logic        entry_found_o,
  output logic        entry_inserted_o,
  output logic [5:0]  entry_slot_o,
  output logic [6:0]  entry_count_o,
  output logic        mark_applied_o,
  output logic        listening_now_o
);
  import sst_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [15:0] rssi_lvl_q;
  logic [15:0] noise_lvl_q;
  logic [5:0]  hyst_q;

  // Table bookkeeping.
  sst_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] la_slot_q, la_slot_d;
  logic              la_valid_q, la_valid_d;
  logic              listen_q, listen_d;

  // Word under work.
  logic [1:0]  req_q;
  logic [31:0] freq_q;
  logic [15:0] rssi_q;
  logic        open_q;

  // Search outcome.
  logic              hit_q;
  logic [SLOT_W-1:0] hit_slot_q;
  entry_t            hit_ent_q;

  // Result under construction.
  logic              r_open_q, r_open_d;
  logic              r_found_q, r_found_d;
  logic              r_ins_q, r_ins_d;
  logic [SLOT_W-1:0] r_slot_q, r_slot_d;
  logic              r_mark_q, r_mark_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic       o_open_q, o_found_q, o_ins_q, o_mark_q, o_listen_q;
  logic [5:0] o_slot_q;
  logic [6:0] o_count_q;

  logic              in_fire;
  logic              load_out;
  logic [15:0]       noise_limit;
  logic              open_now;
  logic              open_fin;
  logic              has_room;
  logic [8:0]        slot_wide;
  logic [8:0]        count_wide;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              srch_start;
  logic              srch_rd_en;
  logic [SLOT_W-1:0] srch_rd_addr;
  logic [SLOT_W-1:0] srch_slot;
  srch_res_t         srch_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // While listening, the noise limit drops by the hysteresis (wrapping).
  assign noise_limit = listen_q ? (noise_lvl_q - {10'd0, hyst_q}) : noise_lvl_q;
  assign open_now    = (rssi_value_i >= rssi_lvl_q) && (noise_value_i <= noise_limit);
  assign has_room    = (count_q < CNT_W'(TABLE_DEPTH));

  sst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sst_search #(
    .DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (srch_start),
    .count_i   (count_q),
    .freq_i    (freq_q),
    .rd_data_i (ram_rdata),
    .rd_en_o   (srch_rd_en),
    .rd_addr_o (srch_rd_addr),
    .slot_o    (srch_slot),
    .res_o     (srch_res)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    la_slot_d  = la_slot_q;
    la_valid_d = la_valid_q;
    listen_d   = listen_q;
    r_open_d   = r_open_q;
    r_found_d  = r_found_q;
    r_ins_d    = r_ins_q;
    r_slot_d   = r_slot_q;
    r_mark_d   = r_mark_q;
    srch_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = la_slot_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = la_slot_q;
    open_fin   = open_q;
    load_out   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          r_open_d  = 1'b0;
          r_found_d = 1'b0;
          r_ins_d   = 1'b0;
          r_slot_d  = '0;
          r_mark_d  = 1'b0;
          if (req_type_i == REQ_MEAS) begin
            srch_start = 1'b1;
            state_d    = ST_SEARCH;
          end else if (req_type_i == REQ_BLACK || req_type_i == REQ_GOOD) begin
            if (req_type_i == REQ_BLACK) begin
              listen_d = 1'b0;
            end
            state_d = la_valid_q ? ST_MARK_RD : ST_RESULT;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SEARCH: begin
        ram_re    = srch_rd_en;
        ram_raddr = srch_rd_addr;
        if (srch_res.done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (hit_q) begin
          open_fin  = open_q && !(hit_ent_q.blacklisted || hit_ent_q.marked_good);
          ram_we    = 1'b1;
          ram_waddr = hit_slot_q;
          ram_wdata = '{freq: freq_q, rssi: rssi_q, is_open: open_fin,
                        blacklisted: hit_ent_q.blacklisted,
                        marked_good: hit_ent_q.marked_good};
          if (hit_ent_q.is_open) begin
            la_slot_d  = hit_slot_q;
            la_valid_d = 1'b1;
          end
          r_found_d = 1'b1;
          r_slot_d  = hit_slot_q;
        end else if (open_q && has_room) begin
          // A new entry is stored open, so it becomes the last-active one.
          open_fin   = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = count_q[SLOT_W-1:0];
          ram_wdata  = '{freq: freq_q, rssi: rssi_q, is_open: 1'b1,
                         blacklisted: 1'b0, marked_good: 1'b0};
          count_d    = count_q + 1'b1;
          la_slot_d  = count_q[SLOT_W-1:0];
          la_valid_d = 1'b1;
          r_found_d  = 1'b1;
          r_ins_d    = 1'b1;
          r_slot_d   = count_q[SLOT_W-1:0];
        end
        listen_d = open_fin;
        r_open_d = open_fin;
        state_d  = ST_RESULT;
      end
      ST_MARK_RD: begin
        ram_re  = 1'b1;
        state_d = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{freq: ram_rdata.freq, rssi: ram_rdata.rssi,
                      is_open: ram_rdata.is_open,
                      blacklisted: (req_q == REQ_BLACK),
                      marked_good: (req_q == REQ_GOOD)};
        r_mark_d  = 1'b1;
        r_found_d = 1'b1;
        r_slot_d  = la_slot_q;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign slot_wide   = 9'(r_slot_q);
  assign count_wide  = 9'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_lvl_q  <= RSSI_LVL_RST;
      noise_lvl_q <= NOISE_LVL_RST;
      hyst_q      <= HYST_RST;
      state_q     <= ST_IDLE;
      count_q     <= '0;
      la_slot_q   <= '0;
      la_valid_q  <= 1'b0;
      listen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RSSI_LVL:  rssi_lvl_q  <= cfg_wdata_i;
          CFG_NOISE_LVL: noise_lvl_q <= cfg_wdata_i;
          CFG_HYST:      hyst_q      <= cfg_wdata_i[5:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      count_q     <= count_d;
      la_slot_q   <= la_slot_d;
      la_valid_q  <= la_valid_d;
      listen_q    <= listen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= req_type_i;
      freq_q <= frequency_i;
      rssi_q <= rssi_value_i;
      open_q <= open_now;
    end
    if (state_q == ST_SEARCH && srch_res.done) begin
      hit_q      <= srch_res.found;
      hit_slot_q <= srch_slot;
      hit_ent_q  <= srch_res.entry;
    end
    r_open_q  <= r_open_d;
    r_found_q <= r_found_d;
    r_ins_q   <= r_ins_d;
    r_slot_q  <= r_slot_d;
    r_mark_q  <= r_mark_d;
    if (load_out) begin
      o_open_q   <= r_open_q;
      o_found_q  <= r_found_q;
      o_ins_q    <= r_ins_q;
      o_slot_q   <= slot_wide[5:0];
      o_count_q  <= count_wide[6:0];
      o_mark_q   <= r_mark_q;
      o_listen_q <= listen_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign squelch_open_o   = o_open_q;
  assign entry_found_o    = o_found_q;
  assign entry_inserted_o = o_ins_q;
  assign entry_slot_o     = o_slot_q;
  assign entry_count_o    = o_count_q;
  assign mark_applied_o   = o_mark_q;
  assign listening_now_o  = o_listen_q;

endmodule

@@ rtl/core/sst_checker.sv @@
module sst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       squelch_open_o,
  input logic       entry_found_o,
  input logic       entry_inserted_o,
  input logic [6:0] entry_count_o,
  input logic       mark_applied_o
);

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Each accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted back to back");

  // An inserted entry is a found entry, and the table is not empty after it.
  a_insert_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_inserted_o |-> entry_found_o && (entry_count_o != 7'd0))
    else $error("insertion without a table entry");

  // A result with a mark applied never reports an open squelch or an insertion.
  a_mark_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mark_applied_o |-> !squelch_open_o && !entry_inserted_o)
    else $error("mark result carries measurement flags");

endmodule

bind squelch_signal_table_top sst_checker u_sst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .squelch_open_o   (squelch_open_o),
  .entry_found_o    (entry_found_o),
  .entry_inserted_o (entry_inserted_o),
  .entry_count_o    (entry_count_o),
  .mark_applied_o   (mark_applied_o)
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  // The request code and the register index that the package leaves unnamed.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 225;
  // The limit covers a full-table search with ample room for sender gaps and
  // receiver stalls on top of it.
  localparam int STUCK_LIMIT = 4000;

  // One result word, in the order of the output ports.
  typedef struct packed {
    logic       is_open;
    logic       found;
    logic       inserted;
    logic [5:0] slot;
    logic [6:0] count;
    logic       marked;
    logic       listening;
  } verdict_t;

  // One row of the directed part. When hand_set is high, the verdict column is
  // the expected result; otherwise the result comes from the predictor.
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] freq;
    logic [15:0] rssi;
    logic [15:0] noise;
    logic        hand_set;
    verdict_t    verdict;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_RSSI_LVL;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_MEAS;
  logic [31:0] frequency_i = '0;
  logic [15:0] rssi_value_i = '0;
  logic [15:0] noise_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        squelch_open_o;
  logic        entry_found_o;
  logic        entry_inserted_o;
  logic [5:0]  entry_slot_o;
  logic [6:0]  entry_count_o;
  logic        mark_applied_o;
  logic        listening_now_o;

  squelch_signal_table_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .frequency_i      (frequency_i),
    .rssi_value_i     (rssi_value_i),
    .noise_value_i    (noise_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .squelch_open_o   (squelch_open_o),
    .entry_found_o    (entry_found_o),
    .entry_inserted_o (entry_inserted_o),
    .entry_slot_o     (entry_slot_o),
    .entry_count_o    (entry_count_o),
    .mark_applied_o   (mark_applied_o),
    .listening_now_o  (listening_now_o)
  );

  always #4 clk_i = ~clk_i;

  // Our own copy of the signal table, its bookkeeping and the registers.
  entry_t      heard [DEPTH];
  int          heard_used = 0;
  logic [5:0]  last_slot = '0;
  logic        last_valid = 1'b0;
  logic        listening_m = 1'b0;
  logic [15:0] rssi_lvl_m = RSSI_LVL_RST;
  logic [15:0] noise_lvl_m = NOISE_LVL_RST;
  logic [5:0]  hyst_m = HYST_RST;

  verdict_t awaited_verdicts [$];
  int       mismatches = 0;
  // While calm is set, neither side idles; one random phase runs that way.
  logic     calm = 1'b0;

  // Squelch decision and table update for one accepted word. The noise limit
  // drops by the hysteresis while listening, wrapping at 16 bits.
  task automatic judge_word(input logic [1:0] req, input logic [31:0] freq,
                            input logic [15:0] rssi, input logic [15:0] noise,
                            output verdict_t v);
    logic [15:0] limit;
    logic        opens;
    int          hit;
    int          i;
    v = '0;
    if (req == REQ_MEAS) begin
      limit = listening_m ? noise_lvl_m - 16'(hyst_m) : noise_lvl_m;
      opens = (rssi >= rssi_lvl_m) && (noise <= limit);
      hit = -1;
      for (i = 0; i < heard_used && hit < 0; i++) begin
        if (heard[i].freq == freq) hit = i;
      end
      // Only an open, unknown signal earns a slot, and only while there is one.
      if (hit < 0 && opens && heard_used < DEPTH) begin
        hit = heard_used;
        heard[hit] = '{freq: freq, rssi: rssi, is_open: 1'b1,
                       blacklisted: 1'b0, marked_good: 1'b0};
        heard_used++;
        v.inserted = 1'b1;
      end
      if (hit >= 0) begin
        if (heard[hit].blacklisted || heard[hit].marked_good) opens = 1'b0;
        heard[hit].rssi = rssi;
        // An entry that was open before this word becomes the last-active one.
        if (heard[hit].is_open) begin
          last_slot = 6'(hit);
          last_valid = 1'b1;
        end
        heard[hit].is_open = opens;
        v.found = 1'b1;
        v.slot = 6'(hit);
      end
      listening_m = opens;
      v.is_open = opens;
    end else if (req == REQ_BLACK || req == REQ_GOOD) begin
      if (last_valid) begin
        heard[last_slot].blacklisted = (req == REQ_BLACK);
        heard[last_slot].marked_good = (req == REQ_GOOD);
        v.marked = 1'b1;
        v.found = 1'b1;
        v.slot = last_slot;
      end
      if (req == REQ_BLACK) listening_m = 1'b0;
    end
    v.count = 7'(heard_used);
    v.listening = listening_m;
  endtask

  // Writes one register and keeps our copy in step. The caller lowers the
  // write enable once the whole batch of writes is done.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_RSSI_LVL:  rssi_lvl_m = data;
      CFG_NOISE_LVL: noise_lvl_m = data;
      CFG_HYST:      hyst_m = data[5:0];
      default: ;
    endcase
  endtask

  // Offers one word, after a random gap unless calm is set, and holds it until it is
  // taken. The expectation is queued at the edge where the block accepts the word.
  task automatic send_word(input logic [1:0] req, input logic [31:0] freq,
                           input logic [15:0] rssi, input logic [15:0] noise,
                           input logic hand_set, input verdict_t hand_v);
    verdict_t v;
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    frequency_i <= freq;
    rssi_value_i <= rssi;
    noise_value_i <= noise;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    judge_word(req, freq, rssi, noise, v);
    awaited_verdicts.push_back(hand_set ? hand_v : v);
  endtask

  // The directed part runs with the reset values of the registers. The noise
  // level of zero makes the listening limit wrap around to 65522.
  probe_t probes [0:21] = '{
    // A closed measurement of an unknown frequency is dropped.
    '{REQ_MEAS,  32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 6'd0, 7'd0, 0, 0}},
    // Commands with no last-active entry mark nothing.
    '{REQ_BLACK, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 6'd0, 7'd0, 0, 0}},
    '{REQ_GOOD,  32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 6'd0, 7'd0, 0, 0}},
    // The unused request code changes nothing.
    '{REQ_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 0, 0, 6'd0, 7'd0, 0, 0}},
    '{REQ_MEAS,  32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1, '{1, 1, 1, 6'd0, 7'd1, 0, 1}},
    // Noise exactly at the wrapped listening limit still opens.
    '{REQ_MEAS,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFF2, 1'b1, '{1, 1, 0, 6'd0, 7'd1, 0, 1}},
    '{REQ_MEAS,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFF3, 1'b1, '{0, 1, 0, 6'd0, 7'd1, 0, 0}},
    '{REQ_BLACK, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 1, 0, 6'd0, 7'd1, 1, 0}},
    // A blacklisted entry stays closed.
    '{REQ_MEAS,  32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1, '{0, 1, 0, 6'd0, 7'd1, 0, 0}},
    '{REQ_MEAS,  32'h0000_0000, 16'hFFFF, 16'h0000, 1'b1, '{1, 1, 1, 6'd1, 7'd2, 0, 1}},
    // Mark good leaves listening as it was.
    '{REQ_GOOD,  32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 1, 0, 6'd1, 7'd2, 1, 1}},
    '{REQ_MEAS,  32'h0000_0000, 16'hFFFF, 16'h0000, 1'b1, '{0, 1, 0, 6'd1, 7'd2, 0, 0}},
    // RSSI one below the level, then noise one above it.
    '{REQ_MEAS,  32'h0000_0001, 16'hFFFE, 16'h0000, 1'b1, '{0, 0, 0, 6'd0, 7'd2, 0, 0}},
    '{REQ_MEAS,  32'h0000_0001, 16'hFFFF, 16'h0001, 1'b1, '{0, 0, 0, 6'd0, 7'd2, 0, 0}},
    '{REQ_MEAS,  32'h5555_AAAA, 16'hFFFF, 16'h0000, 1'b1, '{1, 1, 1, 6'd2, 7'd3, 0, 1}},
    '{REQ_MEAS,  32'hAAAA_5555, 16'hFFFF, 16'h0000, 1'b1, '{1, 1, 1, 6'd3, 7'd4, 0, 1}},
    '{REQ_BLACK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 1, 0, 6'd3, 7'd4, 1, 0}},
    // A second mark on the same entry replaces the first.
    '{REQ_GOOD,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 1, 0, 6'd3, 7'd4, 1, 0}},
    '{REQ_MEAS,  32'hAAAA_5555, 16'hFFFF, 16'h0000, 1'b1, '{0, 1, 0, 6'd3, 7'd4, 0, 0}},
    '{REQ_SPARE, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 6'd0, 7'd4, 0, 0}},
    '{REQ_MEAS,  32'h5555_AAAA, 16'h8000, 16'h0000, 1'b0, '0},
    '{REQ_MEAS,  32'h1234_5678, 16'hFFFF, 16'h0000, 1'b0, '0}
  };

  // Register settings per random phase; a negative entry means a random value.
  // The plan walks the extremes and includes hysteresis values above 40 and
  // settings where the listening limit wraps.
  int rssi_plan  [PHASES] = '{32'h8000, 0, -1, 65535, -1, 0};
  int noise_plan [PHASES] = '{32'h4000, 65535, -1, 0, -1, 10};
  int hyst_plan  [PHASES] = '{40, 1, 63, 14, -1, 40};

  initial begin : stimulus
    logic [31:0] freq_pool [96];
    logic [1:0]  req;
    logic [31:0] freq;
    logic [15:0] rssi;
    logic [15:0] noise;
    logic [15:0] limit;
    int          pick;
    int          pool_n;
    int          fresh_pct;
    int          value;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[k]) begin
      send_word(probes[k].req, probes[k].freq, probes[k].rssi, probes[k].noise,
                probes[k].hand_set, probes[k].verdict);
    end

    foreach (freq_pool[k]) freq_pool[k] = $urandom;

    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers may only change while the block is idle, so drain first.
      in_valid_i <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clk_i);
      calm = (ph == 2);
      value = rssi_plan[ph];
      write_reg(CFG_RSSI_LVL, (value < 0) ? 16'($urandom) : 16'(value));
      value = noise_plan[ph];
      write_reg(CFG_NOISE_LVL, (value < 0) ? 16'($urandom) : 16'(value));
      value = hyst_plan[ph];
      // The upper bits of the data word carry noise the register must drop.
      write_reg(CFG_HYST, {10'($urandom),
                           (value < 0) ? 6'($urandom_range(1, 63)) : 6'(value)});
      // Writes to the spare index are ignored.
      write_reg(CFG_SPARE, 16'($urandom));
      cfg_we_i <= 1'b0;

      // A small set of frequencies early keeps the table below full for a
      // while; later phases bring in more new frequencies and fill it.
      pool_n = (ph < 3) ? 40 : 96;
      fresh_pct = (ph < 3) ? 3 : 20;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) req = REQ_MEAS;
        else if (pick < 88) req = REQ_BLACK;
        else if (pick < 97) req = REQ_GOOD;
        else req = REQ_SPARE;

        if ($urandom_range(0, 99) < fresh_pct) freq = $urandom;
        else freq = freq_pool[$urandom_range(0, pool_n - 1)];

        // Most measurements aim at an open squelch or sit right on a
        // threshold; the rest are arbitrary.
        limit = listening_m ? noise_lvl_m - 16'(hyst_m) : noise_lvl_m;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            rssi = 16'($urandom_range(rssi_lvl_m, 65535));
            noise = 16'($urandom_range(0, limit));
          end
          5: begin
            rssi = rssi_lvl_m;
            noise = limit;
          end
          6: begin
            rssi = rssi_lvl_m - 16'd1;
            noise = limit;
          end
          7: begin
            rssi = rssi_lvl_m;
            noise = limit + 16'd1;
          end
          default: begin
            rssi = 16'($urandom);
            noise = 16'($urandom);
          end
        endcase
        send_word(req, freq, rssi, noise, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    // Any stray result word shows up within a full search time.
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // The receiver stalls at random, except in the calm phase.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 28);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Every taken result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: result word with none expected", $time);
        mismatches++;
      end else begin
        want = awaited_verdicts.pop_front();
        check_field("squelch_open", want.is_open, squelch_open_o);
        check_field("entry_found", want.found, entry_found_o);
        check_field("entry_inserted", want.inserted, entry_inserted_o);
        check_field("entry_slot", want.slot, entry_slot_o);
        check_field("entry_count", want.count, entry_count_o);
        check_field("mark_applied", want.marked, mark_applied_o);
        check_field("listening_now", want.listening, listening_now_o);
      end
    end
  end

  // The run ends if neither channel moves a word for too long.
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/sst_pkg.sv
rtl/core/sst_ram.sv
rtl/core/sst_search.sv
rtl/core/squelch_signal_table_top.sv
rtl/core/sst_checker.sv
tb/testbench.sv
